/* rtl/uvs_pkg.sv */
package uvs_pkg;

  localparam int MAX_RES_DEF = 256;

  // Field widths fixed by the stream format.
  localparam int RES_W   = 9;
  localparam int TRI_W   = 17;
  localparam int IDX_W   = 20;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 152;

  // Long division of a grid coordinate by the resolution, 33 fraction bits.
  localparam int DIV_NUM_W = 10;
  localparam int DIV_FRAC  = 33;
  localparam int DIV_STEPS = DIV_NUM_W + DIV_FRAC;
  localparam int QUO_W     = 35;

  // Sine/cosine pipeline: two setup stages, three per series term, two at the end.
  localparam int HORNER_N = 6;
  localparam int SC_LAT   = 2 + 3 * HORNER_N + 2;

  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_RINGS   = 2'd2
  } cfg_reg_t;

  // One finished grid point, handed to the output serializer.
  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [5:0][TRI_W-1:0] cand;
    logic [5:0]         keep;
  } rec_t;

  // Unsigned Q30 product, rounded half up.
  function automatic logic [33:0] umul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'(32'h2000_0000);
    return p[63:30];
  endfunction

endpackage

/* rtl/uvs_div_cell.sv */
module uvs_div_cell (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [8:0]              den,
  input  logic [8:0]              rem_in,
  input  logic [9:0]              num_in,
  input  logic [uvs_pkg::QUO_W-1:0] quo_in,
  output logic [8:0]              rem_out,
  output logic [9:0]              num_out,
  output logic [uvs_pkg::QUO_W-1:0] quo_out
);
  import uvs_pkg::*;

  logic [9:0] trial;
  logic       ge;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  assign trial = {rem_in, num_in[9]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out <= ge ? 9'(trial - {1'b0, den}) : trial[8:0];
      num_out <= {num_in[8:0], 1'b0};
      quo_out <= {quo_in[QUO_W-2:0], ge};
    end
  end

endmodule

/* rtl/uvs_horner_cell.sv */
module uvs_horner_cell #(
  parameter int DS = 156,
  parameter int DC = 182
) (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] x_in,
  input  logic [31:0] x2_in,
  input  logic [31:0] ts_in,
  input  logic [31:0] tc_in,
  input  logic [1:0]  quad_in,
  output logic [31:0] x_out,
  output logic [31:0] x2_out,
  output logic [31:0] ts_out,
  output logic [31:0] tc_out,
  output logic [1:0]  quad_out
);
  import uvs_pkg::*;

  // Reciprocals for the constant divides; the estimate is at most one low.
  localparam logic [63:0] RS = (64'd1 << 32) / DS;
  localparam logic [63:0] RC = (64'd1 << 32) / DC;

  logic [31:0] ps_a, pc_a, ps_b, pc_b, qs_b, qc_b;
  logic [31:0] x_a, x2_a, x_b, x2_b;
  logic [1:0]  quad_a, quad_b;
  logic [63:0] es, ec;
  logic [31:0] rs, rc, qs, qc;
  logic [33:0] ps_full, pc_full;

  assign ps_full = umul_q30(x2_in, ts_in);
  assign pc_full = umul_q30(x2_in, tc_in);
  assign es = 64'(ps_a) * RS;
  assign ec = 64'(pc_a) * RC;
  assign rs = ps_b - 32'(qs_b * 32'(DS));
  assign rc = pc_b - 32'(qc_b * 32'(DC));
  assign qs = qs_b + 32'(rs >= 32'(DS));
  assign qc = qc_b + 32'(rc >= 32'(DC));

  always_ff @(posedge clk) begin
    if (adv) begin
      ps_a     <= ps_full[31:0];
      pc_a     <= pc_full[31:0];
      x_a      <= x_in;
      x2_a     <= x2_in;
      quad_a   <= quad_in;
      ps_b     <= ps_a;
      pc_b     <= pc_a;
      qs_b     <= es[63:32];
      qc_b     <= ec[63:32];
      x_b      <= x_a;
      x2_b     <= x2_a;
      quad_b   <= quad_a;
      ts_out   <= Q30_ONE - qs;
      tc_out   <= Q30_ONE - qc;
      x_out    <= x_b;
      x2_out   <= x2_b;
      quad_out <= quad_b;
    end
  end

endmodule

/* rtl/uvs_sincos.sv */
module uvs_sincos (
  input  logic               clk,
  input  logic               adv,
  input  logic [31:0]        ang,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);
  import uvs_pkg::*;

  localparam int SDIV [HORNER_N] = '{156, 110, 72, 42, 20, 6};
  localparam int CDIV [HORNER_N] = '{182, 132, 90, 56, 30, 12};

  logic [31:0] x1, x_2, x2_2;
  logic [1:0]  q1, q2, qf;
  logic [31:0] hx [0:HORNER_N];
  logic [31:0] hx2 [0:HORNER_N];
  logic [31:0] hts [0:HORNER_N];
  logic [31:0] htc [0:HORNER_N];
  logic [1:0]  hq [0:HORNER_N];
  logic [33:0] s_raw, c_prod, c_half;
  logic [33:0] x1_full, x2_full;
  logic [30:0] sf, cf;

  assign hx[0]  = x_2;
  assign hx2[0] = x2_2;
  assign hts[0] = Q30_ONE;
  assign htc[0] = Q30_ONE;
  assign hq[0]  = q2;

  for (genvar i = 0; i < HORNER_N; i++) begin : g_cell
    uvs_horner_cell #(.DS(SDIV[i]), .DC(CDIV[i])) u_cell (
      .clk      (clk),
      .adv      (adv),
      .x_in     (hx[i]),
      .x2_in    (hx2[i]),
      .ts_in    (hts[i]),
      .tc_in    (htc[i]),
      .quad_in  (hq[i]),
      .x_out    (hx[i+1]),
      .x2_out   (hx2[i+1]),
      .ts_out   (hts[i+1]),
      .tc_out   (htc[i+1]),
      .quad_out (hq[i+1])
    );
  end

  assign x1_full = umul_q30({2'b00, ang[29:0]}, HALF_PI_Q30);
  assign x2_full = umul_q30(x1, x1);
  assign s_raw  = umul_q30(hx[HORNER_N], hts[HORNER_N]);
  assign c_prod = umul_q30(hx2[HORNER_N], htc[HORNER_N]);
  assign c_half = c_prod >> 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1   <= x1_full[31:0];
      q1   <= ang[31:30];
      x_2  <= x1;
      x2_2 <= x2_full[31:0];
      q2   <= q1;
      sf   <= (s_raw > 34'(Q30_ONE)) ? Q30_ONE[30:0] : s_raw[30:0];
      cf   <= (c_half >= 34'(Q30_ONE)) ? 31'd0 : 31'(Q30_ONE - c_half[31:0]);
      qf   <= hq[HORNER_N];
      unique case (qf)
        2'd0: begin
          sin_q <= $signed({1'b0, sf});
          cos_q <= $signed({1'b0, cf});
        end
        2'd1: begin
          sin_q <= $signed({1'b0, cf});
          cos_q <= -$signed({1'b0, sf});
        end
        2'd2: begin
          sin_q <= -$signed({1'b0, sf});
          cos_q <= -$signed({1'b0, cf});
        end
        default: begin
          sin_q <= -$signed({1'b0, cf});
          cos_q <= $signed({1'b0, sf});
        end
      endcase
    end
  end

endmodule

/* rtl/uvs_out_ser.sv */
module uvs_out_ser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rec_valid,
  input  uvs_pkg::rec_t             rec,
  output logic                      rec_ready,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [uvs_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tuser,
  output logic                      m_tlast
);
  import uvs_pkg::*;

  rec_t        hold;
  logic [6:0]  pend;
  logic [6:0]  pend_rest;
  logic        take;
  logic [TRI_W-1:0] tri_sel;

  assign pend_rest = pend & (pend - 7'd1);
  assign m_tvalid  = |pend;
  assign m_tlast   = (pend_rest == 7'd0);
  assign m_tuser   = pend[0];
  assign take      = m_tvalid && m_tready;
  assign rec_ready = !m_tvalid || (take && m_tlast);

  // Lowest pending index record wins.
  always_comb begin
    tri_sel = '0;
    for (int i = 5; i >= 0; i--) begin
      if (pend[i+1]) tri_sel = hold.cand[i];
    end
  end

  always_comb begin
    if (pend[0]) begin
      m_tdata = {4'b0, TRI_W'(0), hold.tex_v, hold.tex_u, hold.norm_z, hold.norm_y,
                 hold.norm_x, hold.pos_z, hold.pos_y, hold.pos_x};
    end else begin
      m_tdata = {4'b0, tri_sel, 131'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (rec_ready && rec_valid) begin
      pend <= {rec.keep, 1'b1};
    end else if (take) begin
      pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) hold <= rec;
  end

endmodule

/* rtl/uv_sphere_vertex_generator_core.sv */
// Throughput: the pipeline takes one input beat per cycle while no finished point waits
// on the serializer; each grid point leaves as one vertex beat plus one beat per kept
// triangle index, one beat at a time through the single output port of the serializer.
// Reset (synchronous, rst high): pipeline and serializer empty, registers at defaults.
module uv_sphere_vertex_generator_core #(
  parameter int MAX_RES = uvs_pkg::MAX_RES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write port.
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data,
  // Input stream. tdata: ring [8:0], column [17:9], zero fill above.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [uvs_pkg::IN_W-1:0]  s_tdata,
  // Output stream. tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
  // tri_index, from bit 0 up, zero fill above. tuser: is_vertex. tlast: last.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [uvs_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tuser,
  output logic                      m_tlast
);
  import uvs_pkg::*;

  // Resolutions saturate at the configured maximum; the register width caps it too.
  localparam int RES_CAP = (MAX_RES > 511) ? 511 : MAX_RES;

  // Pipeline stage numbers. Stage 0 is the input register; the divider cells follow,
  // then the angle stage, the two sine/cosine units and four output stages.
  localparam int S_ANG  = DIV_STEPS + 1;
  localparam int S_SC   = S_ANG + SC_LAT;
  localparam int S_T1   = S_SC + 1;
  localparam int S_T2   = S_T1 + 1;
  localparam int S_T3   = S_T2 + 1;
  localparam int S_LAST = S_T3 + 1;

  logic [15:0] radius_r;
  logic [8:0]  columns_r, rings_r;
  logic [8:0]  nc_c, nr_c;
  logic [IDX_W-1:0] verts_r;

  logic        adv;
  logic        ser_ready;
  logic [S_LAST:0] v;

  function automatic logic [8:0] clamp_res(input logic [8:0] r);
    if (r == 9'd0) return 9'd1;
    if (r > 9'(RES_CAP)) return 9'(RES_CAP);
    return r;
  endfunction

  assign nc_c = clamp_res(columns_r);
  assign nr_c = clamp_res(rings_r);

  // Configuration registers. Writes to the unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_r  <= 16'd256;
      columns_r <= 9'd16;
      rings_r   <= 9'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:  radius_r  <= cfg_data;
        REG_COLUMNS: columns_r <= cfg_data[8:0];
        REG_RINGS:   rings_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Vertex count follows registers; only change them while the pipe is empty; not enforced.
  always_ff @(posedge clk) begin
    verts_r <= IDX_W'((IDX_W'(nr_c) + IDX_W'(1)) * (IDX_W'(nc_c) + IDX_W'(1)));
  end

  // The whole pipe moves as one unless a finished point waits on the serializer.
  assign adv      = !v[S_LAST] || ser_ready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[S_LAST-1:0], s_tvalid};
    end
  end

  // Grid coordinates, saturated on entry and carried to the index stage.
  logic [8:0] ring_d [0:S_T2];
  logic [8:0] col_d  [0:S_T2];
  logic [8:0] s_ring, s_col;

  assign s_ring = s_tdata[8:0];
  assign s_col  = s_tdata[17:9];

  always_ff @(posedge clk) begin
    if (adv) begin
      ring_d[0] <= (s_ring > nr_c) ? nr_c : s_ring;
      col_d[0]  <= (s_col > nc_c) ? nc_c : s_col;
      for (int k = 1; k <= S_T2; k++) begin
        ring_d[k] <= ring_d[k-1];
        col_d[k]  <= col_d[k-1];
      end
    end
  end

  // Three division lanes, one quotient bit per cell: ring/rings, column/columns and
  // (column+1)/columns, each scaled by 2^33 and truncated.
  logic [8:0]       d_rem [0:2][0:DIV_STEPS];
  logic [9:0]       d_num [0:2][0:DIV_STEPS];
  logic [QUO_W-1:0] d_quo [0:2][0:DIV_STEPS];
  logic [8:0]       d_den [0:2];

  assign d_den[0] = nr_c;
  assign d_den[1] = nc_c;
  assign d_den[2] = nc_c;
  assign d_num[0][0] = {1'b0, ring_d[0]};
  assign d_num[1][0] = {1'b0, col_d[0]};
  assign d_num[2][0] = 10'({1'b0, col_d[0]} + 10'd1);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign d_rem[l][0] = '0;
    assign d_quo[l][0] = '0;
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      uvs_div_cell u_cell (
        .clk     (clk),
        .adv     (adv),
        .den     (d_den[l]),
        .rem_in  (d_rem[l][k]),
        .num_in  (d_num[l][k]),
        .quo_in  (d_quo[l][k]),
        .rem_out (d_rem[l][k+1]),
        .num_out (d_num[l][k+1]),
        .quo_out (d_quo[l][k+1])
      );
    end
  end

  // Rounded angles and texture coordinates. Shifting a truncated quotient down to one bit
  // above the result and adding one before the final shift gives the round-to-nearest result.
  logic [QUO_W-1:0] qr, qc, qt;
  logic [31:0] phi_a, theta_a;
  logic [15:0] texu_d [S_ANG:S_T3];
  logic [15:0] texv_d [S_ANG:S_T3];

  assign qr = d_quo[0][DIV_STEPS];
  assign qc = d_quo[1][DIV_STEPS];
  assign qt = d_quo[2][DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      phi_a         <= 32'(((qr >> 1) + QUO_W'(1)) >> 1);
      theta_a       <= 32'((qt + QUO_W'(1)) >> 1);
      texv_d[S_ANG] <= 16'(((qr >> 17) + QUO_W'(1)) >> 1);
      texu_d[S_ANG] <= 16'(((qc >> 17) + QUO_W'(1)) >> 1);
      for (int k = S_ANG + 1; k <= S_T3; k++) begin
        texv_d[k] <= texv_d[k-1];
        texu_d[k] <= texu_d[k-1];
      end
    end
  end

  logic signed [31:0] sp, cp, st, ct;

  uvs_sincos u_phi (
    .clk   (clk),
    .adv   (adv),
    .ang   (phi_a),
    .sin_q (sp),
    .cos_q (cp)
  );

  uvs_sincos u_theta (
    .clk   (clk),
    .adv   (adv),
    .ang   (theta_a),
    .sin_q (st),
    .cos_q (ct)
  );

  // Direction in sign and magnitude form: dx = sin(phi)cos(theta), dy = cos(phi),
  // dz = -sin(phi)sin(theta). A zero magnitude makes the sign harmless.
  logic [30:0] m_sp, m_cp, m_st, m_ct;
  logic        g_sp, g_cp, g_st, g_ct;
  logic [30:0] mdx, mdy, mdz;
  logic        ndx2, ndy2, ndz2, ndx3, ndy3, ndz3;
  logic [47:0] px_full, py_full, pz_full;
  logic [33:0] dx_full, dz_full;
  logic [16:0] pmx, pmy, pmz;
  logic [15:0] nmx, nmy, nmz;
  logic [IDX_W-1:0] a3;
  logic [8:0]  t3;

  function automatic logic [30:0] mag31(input logic signed [31:0] d);
    return d[31] ? 31'(-d) : d[30:0];
  endfunction

  function automatic logic [15:0] norm_mag(input logic [30:0] m);
    return 16'((32'(m) + 32'h4000) >> 15);
  endfunction

  function automatic logic signed [16:0] pos_val(input logic neg, input logic [16:0] m);
    return neg ? $signed(17'd0 - m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] norm_val(input logic neg, input logic [15:0] m);
    if (neg) return $signed(16'(17'd0 - 17'(m)));
    if (m > 16'd32767) return 16'sd32767;
    return $signed(m);
  endfunction

  assign dx_full = umul_q30(32'(m_sp), 32'(m_ct));
  assign dz_full = umul_q30(32'(m_sp), 32'(m_st));
  assign px_full = 48'(mdx) * 48'(radius_r) + 48'(32'h2000_0000);
  assign py_full = 48'(mdy) * 48'(radius_r) + 48'(32'h2000_0000);
  assign pz_full = 48'(mdz) * 48'(radius_r) + 48'(32'h2000_0000);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sp <= mag31(sp);
      m_cp <= mag31(cp);
      m_st <= mag31(st);
      m_ct <= mag31(ct);
      g_sp <= sp[31];
      g_cp <= cp[31];
      g_st <= st[31];
      g_ct <= ct[31];

      mdx  <= dx_full[30:0];
      mdz  <= dz_full[30:0];
      mdy  <= m_cp;
      ndx2 <= g_sp ^ g_ct;
      ndz2 <= ~(g_sp ^ g_st);
      ndy2 <= g_cp;

      pmx  <= px_full[46:30];
      pmy  <= py_full[46:30];
      pmz  <= pz_full[46:30];
      nmx  <= norm_mag(mdx);
      nmy  <= norm_mag(mdy);
      nmz  <= norm_mag(mdz);
      ndx3 <= ndx2;
      ndy3 <= ndy2;
      ndz3 <= ndz2;
      a3   <= IDX_W'(IDX_W'(ring_d[S_T2]) * (IDX_W'(nc_c) + IDX_W'(1)));
      t3   <= col_d[S_T2];
    end
  end

  // Last stage: signs applied, the six quad corners formed and tested against the
  // vertex count. The last column's right corner wraps into the next row.
  rec_t rec4, rec_next;
  logic [IDX_W-1:0] b3, at, bt;
  logic [IDX_W-1:0] cand_w [6];

  assign b3 = a3 + IDX_W'(nc_c) + IDX_W'(1);
  assign at = a3 + IDX_W'(t3);
  assign bt = b3 + IDX_W'(t3);
  assign cand_w[0] = at;
  assign cand_w[1] = bt;
  assign cand_w[2] = at + IDX_W'(1);
  assign cand_w[3] = at + IDX_W'(1);
  assign cand_w[4] = bt;
  assign cand_w[5] = bt + IDX_W'(1);

  always_comb begin
    rec_next.pos_x  = pos_val(ndx3, pmx);
    rec_next.pos_y  = pos_val(ndy3, pmy);
    rec_next.pos_z  = pos_val(ndz3, pmz);
    rec_next.norm_x = norm_val(ndx3, nmx);
    rec_next.norm_y = norm_val(ndy3, nmy);
    rec_next.norm_z = norm_val(ndz3, nmz);
    rec_next.tex_u  = texu_d[S_T3];
    rec_next.tex_v  = texv_d[S_T3];
    for (int i = 0; i < 6; i++) begin
      rec_next.cand[i] = cand_w[i][TRI_W-1:0];
      rec_next.keep[i] = (cand_w[i] < verts_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rec4 <= rec_next;
  end

  uvs_out_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (v[S_LAST]),
    .rec       (rec4),
    .rec_ready (ser_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // After the closing beat of a point, the next beat shown is a vertex beat.
  a_vertex_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tuser)
    else $error("beat after a closing beat is not a vertex beat");

  // A beat that does not close its point is followed by an index beat of that point.
  a_index_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser)
    else $error("open point lost its remaining index beats");

  // A finished point that the serializer cannot take freezes the pipe.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[S_LAST] && !ser_ready |=> v[S_LAST] && $stable(rec4))
    else $error("finished point changed while waiting for the serializer");

endmodule
